// File: rtl/v3dl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// v3dl_pkg
// Shared types and constants for the vector dot product and length block.
// ----------------------------------------------------------------------------
package v3dl_pkg;

  localparam int unsigned DotWidth  = 64;
  localparam int unsigned WordWidth = 32;
  localparam int unsigned KWidth    = 5;
  localparam int unsigned RootWidth = 16;

  // Square root pipeline: sixteen restoring iterations, a few per stage.
  localparam int unsigned SqrtIters        = 16;
  localparam int unsigned SqrtIterPerStage = 2;
  localparam int unsigned SqrtStages       = SqrtIters / SqrtIterPerStage;

  // Bias in k = (Bias - count) >> 1.
  localparam logic [5:0] SignRunBias = 6'h23;

  // Data that rides along the square root pipeline beside the radicand.
  typedef struct packed {
    logic [DotWidth-1:0] dot;
    logic [KWidth-1:0]   k;
  } side_t;

endpackage
`default_nettype wire

// File: rtl/v3dl_sqrt_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// v3dl_sqrt_pipe
// Pipelined floor square root of a 32-bit unsigned value, with side data.
// ----------------------------------------------------------------------------
module v3dl_sqrt_pipe (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [31:0]              in_radicand_i,
  input  v3dl_pkg::side_t          in_side_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [15:0]              out_root_o,
  output v3dl_pkg::side_t          out_side_o
);
  import v3dl_pkg::*;

  typedef struct packed {
    logic [WordWidth-1:0] rem;
    logic [WordWidth-1:0] root;
  } sq_t;

  // One restoring step; j selects the trial bit 4^(15-j).
  function automatic sq_t sq_step(input sq_t s, input logic [3:0] j);
    logic [WordWidth-1:0] bit_w;
    logic [WordWidth-1:0] trial;
    sq_t                  r;
    bit_w = 32'h4000_0000 >> {j, 1'b0};
    trial = s.root + bit_w;
    if (s.rem >= trial) begin
      r.rem  = s.rem - trial;
      r.root = (s.root >> 1) + bit_w;
    end else begin
      r.rem  = s.rem;
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  logic  en     [SqrtStages+1];
  logic  v_q    [SqrtStages];
  sq_t   st_q   [SqrtStages];
  side_t side_q [SqrtStages];

  assign en[SqrtStages] = out_ready_i;

  for (genvar s = 0; s < SqrtStages; s++) begin : g_stage
    sq_t   st_in;
    sq_t   st_d;
    logic  v_in;
    side_t side_in;

    if (s == 0) begin : g_first
      assign st_in   = '{rem: in_radicand_i, root: '0};
      assign v_in    = in_valid_i;
      assign side_in = in_side_i;
    end else begin : g_next
      assign st_in   = st_q[s-1];
      assign v_in    = v_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      st_d = st_in;
      for (int t = 0; t < SqrtIterPerStage; t++) begin
        st_d = sq_step(st_d, 4'(s * SqrtIterPerStage + t));
      end
    end

    // A stage takes new data when empty or when its successor moves.
    assign en[s] = !v_q[s] || en[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s] && v_in) begin
        st_q[s]   <= st_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[SqrtStages-1];
  assign out_root_o  = st_q[SqrtStages-1].root[RootWidth-1:0];
  assign out_side_o  = side_q[SqrtStages-1];

endmodule
`default_nettype wire

// File: rtl/vec3_dot_and_length.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vec3_dot_and_length
// Dot product of two signed 32-bit 3-vectors and normalized integer length
// of the first vector.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                  | Beat payload
//  --------+----------------------------+----------------------------------
//  in      | in_valid_i / in_ready_o    | a_x_i a_y_i a_z_i b_x_i b_y_i b_z_i
//  out     | out_valid_o / out_ready_i  | dot_product_o length_of_a_o
//
// A beat accepted at a clock edge passes through thirteen register stages
// before it is presented at the output: four front stages (multiply, sum,
// sign run count, normalize shift), eight square root stages at two
// restoring iterations each, and the output register.
// One beat can enter every cycle while in_ready_o is high; the sixteen-step
// square root is spread over the pipeline so no unit is shared between beats.
// Reset clears only the valid bits of each stage; payload registers are left
// as they are. Every stage loads when it is empty or its successor moves, so
// a stall at the output fills bubbles first and never drops or repeats a beat.
// ----------------------------------------------------------------------------
module vec3_dot_and_length (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] a_z_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] dot_product_o,
  output logic signed [31:0] length_of_a_o
);
  import v3dl_pkg::*;

  // Number of leading bits equal to the sign bit, 1 to 32. A bit differs from
  // its upper neighbor where the xor of the word and its shift is set; the
  // highest such spot ends the run.
  function automatic logic [5:0] sign_run(input logic [31:0] w);
    logic [30:0] diff;
    logic [5:0]  cnt;
    diff = w[31:1] ^ w[30:0];
    cnt  = 6'd32;
    for (int i = 0; i < 31; i++) begin
      if (diff[i]) begin
        cnt = 6'(31 - i);
      end
    end
    return cnt;
  endfunction

  // --------------------------------------------------------------------------
  // Stage enables: a stage loads when empty or when the next one moves.
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  logic sq_in_ready;

  assign en4        = !v4_q || sq_in_ready;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: six signed 32x32 products. Each is exact in 64 bits.
  // --------------------------------------------------------------------------
  logic signed [DotWidth-1:0] prod_d [3];
  logic signed [DotWidth-1:0] sq_d   [3];
  logic signed [DotWidth-1:0] prod_q [3];
  logic signed [DotWidth-1:0] sq_q   [3];

  always_comb begin
    prod_d[0] = 64'(a_x_i) * 64'(b_x_i);
    prod_d[1] = 64'(a_y_i) * 64'(b_y_i);
    prod_d[2] = 64'(a_z_i) * 64'(b_z_i);
    sq_d[0]   = 64'(a_x_i) * 64'(a_x_i);
    sq_d[1]   = 64'(a_y_i) * 64'(a_y_i);
    sq_d[2]   = 64'(a_z_i) * 64'(a_z_i);
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      prod_q <= prod_d;
      sq_q   <= sq_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: wrapping 64-bit sums for the dot product and sum of squares.
  // --------------------------------------------------------------------------
  logic [DotWidth-1:0] dot2_d, ss2_d, dot2_q, ss2_q;

  assign dot2_d = DotWidth'(prod_q[0] + prod_q[1] + prod_q[2]);
  assign ss2_d  = DotWidth'(sq_q[0] + sq_q[1] + sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      dot2_q <= dot2_d;
      ss2_q  <= ss2_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sign run of the high word gives the shift k in 1 to 17.
  // --------------------------------------------------------------------------
  logic [5:0]           run3;
  logic [KWidth-1:0]    k3_d, k3_q;
  logic [DotWidth-1:0]  dot3_q;
  logic [WordWidth-1:0] hi3_q, lo3_q;

  assign run3 = sign_run(ss2_q[63:32]);
  assign k3_d = KWidth'((SignRunBias - run3) >> 1);

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      dot3_q <= dot2_q;
      hi3_q  <= ss2_q[63:32];
      lo3_q  <= ss2_q[31:0];
      k3_q   <= k3_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: narrow the sum of squares to 32 bits by a logical shift of 2k.
  // For k of 16 or 17 the shift amount wraps to 0 or 2 and only the high word
  // is used; below that the shift takes bits from both words.
  // --------------------------------------------------------------------------
  logic [4:0]           sh4;
  logic [WordWidth-1:0] n4_d, n4_q;
  side_t                side4_q;

  assign sh4 = {k3_q[3:0], 1'b0};

  always_comb begin
    if (k3_q[4]) begin
      n4_d = hi3_q >> sh4;
    end else begin
      n4_d = WordWidth'({hi3_q, lo3_q} >> sh4);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      n4_q        <= n4_d;
      side4_q.dot <= dot3_q;
      side4_q.k   <= k3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Square root pipeline.
  // --------------------------------------------------------------------------
  logic                 sq_out_valid;
  logic                 out_en;
  logic [RootWidth-1:0] sq_root;
  side_t                sq_side;

  v3dl_sqrt_pipe u_sqrt (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (v4_q),
    .in_ready_o    (sq_in_ready),
    .in_radicand_i (n4_q),
    .in_side_i     (side4_q),
    .out_valid_o   (sq_out_valid),
    .out_ready_i   (out_en),
    .out_root_o    (sq_root),
    .out_side_o    (sq_side)
  );

  // --------------------------------------------------------------------------
  // Output register: scale the root back up by k, keeping the low 32 bits.
  // --------------------------------------------------------------------------
  logic                 out_valid_q;
  logic [DotWidth-1:0]  dot_q;
  logic [WordWidth-1:0] len_d, len_q;

  assign out_en = !out_valid_q || out_ready_i;
  assign len_d  = WordWidth'(sq_root) << sq_side.k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= sq_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && sq_out_valid) begin
      dot_q <= sq_side.dot;
      len_q <= len_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dot_product_o = dot_q;
  assign length_of_a_o = len_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (k3_q >= 5'd1) && (k3_q <= 5'd17))
    else $error("shift k left its range of 1 to 17");

  a_k_zero_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && (hi3_q == '0) |-> (k3_q == 5'd1))
    else $error("zero high word must give the smallest shift");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted beat did not reach the first stage");

  a_out_fed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(sq_out_valid))
    else $error("output became valid without a beat from the root pipeline");

endmodule
`default_nettype wire
